### design/dfnec_pkg.sv
package dfnec_pkg;

  localparam int TAPS_DEFAULT = 128;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 32;
  localparam int POW_W      = 48;
  localparam int STEP_W     = 16;
  localparam int BLK_W      = 8;
  localparam int RUN_W      = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int FIR_SHIFT   = 28;
  localparam int STEP_SHIFT  = 18;
  localparam int DELTA_SHIFT = 6;
  localparam int TAP_LIM_SH  = 30;

  localparam logic [POW_W-1:0] POW_MAX      = {POW_W{1'b1}};
  localparam logic [POW_W-1:0] ENERGY_FLOOR = 48'd107374;
  localparam logic [POW_W-1:0] DIV_BIAS     = 48'd1073742;
  localparam logic [POW_W-1:0] MARGIN       = 48'd1073741;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  localparam logic [STEP_W-1:0] FAST_STEP_RST = 16'd22938;
  localparam logic [STEP_W-1:0] SLOW_STEP_RST = 16'd2621;
  localparam logic [BLK_W-1:0]  BLOCK_LEN_RST = 8'd80;
  localparam logic [RUN_W-1:0]  PROMOTE_RST   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_STEP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROMOTE   = 8'd3;

  typedef logic [2:0] walk_mode_t;
  localparam walk_mode_t WALK_FIR     = 3'd0;
  localparam walk_mode_t WALK_UPD     = 3'd1;
  localparam walk_mode_t WALK_CLEAR   = 3'd2;
  localparam walk_mode_t WALK_ZERO    = 3'd3;
  localparam walk_mode_t WALK_PROMOTE = 3'd4;
  localparam walk_mode_t WALK_RESTORE = 3'd5;

  typedef logic [1:0] action_t;
  localparam action_t ACT_NONE    = 2'd0;
  localparam action_t ACT_PROMOTE = 2'd1;
  localparam action_t ACT_ZERO    = 2'd2;
  localparam action_t ACT_RESTORE = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       sq_energy;
    logic       energy_upd;
    logic       fir_finish;
    logic       err_calc;
    logic       sq_calc;
    logic       pow_add;
    logic       div_start;
    logic       step_end;
    logic       out_load;
    logic       walk_start;
    walk_mode_t walk_mode;
  } cmd_t;

  typedef struct packed {
    logic    walk_busy;
    logic    div_busy;
    logic    train_en;
    action_t action;
  } sts_t;

endpackage

### design/dfnec_ctrl.sv
module dfnec_ctrl import dfnec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_SQR   = 4'd3;
  localparam logic [3:0] S_ENER  = 4'd4;
  localparam logic [3:0] S_FIR   = 4'd5;
  localparam logic [3:0] S_ERR   = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_POW   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_STEP  = 4'd11;
  localparam logic [3:0] S_ACT   = 4'd12;
  localparam logic [3:0] S_SWEEP = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.walk_start = 1'b1;
        cmd.walk_mode  = WALK_CLEAR;
        state_next     = S_CLEAR;
      end
      S_CLEAR: begin
        if (!sts.walk_busy) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQR;
        end
      end
      S_SQR: begin
        cmd.sq_energy = 1'b1;
        state_next    = S_ENER;
      end
      S_ENER: begin
        cmd.energy_upd = 1'b1;
        cmd.walk_start = 1'b1;
        cmd.walk_mode  = WALK_FIR;
        state_next     = S_FIR;
      end
      S_FIR: begin
        if (!sts.walk_busy) begin
          cmd.fir_finish = 1'b1;
          state_next     = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_calc = 1'b1;
        state_next   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_calc = 1'b1;
        state_next  = S_POW;
      end
      S_POW: begin
        cmd.pow_add = 1'b1;
        if (sts.train_en) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.walk_start = 1'b1;
          cmd.walk_mode  = WALK_UPD;
          state_next     = S_UPD;
        end
      end
      S_UPD: begin
        if (!sts.walk_busy) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step_end = 1'b1;
        state_next   = S_ACT;
      end
      S_ACT: begin
        state_next = S_SWEEP;
        unique case (sts.action)
          ACT_PROMOTE: begin
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = WALK_PROMOTE;
          end
          ACT_ZERO: begin
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = WALK_ZERO;
          end
          ACT_RESTORE: begin
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = WALK_RESTORE;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_SWEEP: begin
        if (!sts.walk_busy) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### design/dfnec_datapath.sv
module dfnec_datapath import dfnec_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0]   reference_sample,
  input  logic signed [SAMPLE_W-1:0]   mic_sample,
  output logic signed [SAMPLE_W-1:0]   residual_sample
);

  localparam int AW    = $clog2(TAPS);
  localparam int PR_W  = SAMPLE_W + TAP_W;
  localparam int ACC_W = PR_W + $clog2(TAPS);
  localparam int Y_W   = ACC_W + 1 - FIR_SHIFT;
  localparam int E_W   = Y_W + 1;
  localparam int SQ_W  = 2 * E_W;
  localparam int PS_W  = SQ_W + 3;
  localparam int P_W   = E_W + STEP_W + 1;
  localparam int NUM_W = P_W + STEP_SHIFT;
  localparam int DEN_W = POW_W + 1;
  localparam int DC_W  = $clog2(NUM_W + 1);
  localparam int U_W   = E_W + 15;
  localparam int UP_W  = U_W + SAMPLE_W;
  localparam int D_W   = UP_W + 1 - DELTA_SHIFT;
  localparam int T_W   = D_W + 1;
  localparam int CW    = POW_W + 4;
  localparam int SQ_IN = 2 * SAMPLE_W;

  localparam logic signed [ACC_W:0] FIR_HALF   = (ACC_W+1)'(1) << (FIR_SHIFT - 1);
  localparam logic signed [UP_W:0]  DELTA_HALF = (UP_W+1)'(1) << (DELTA_SHIFT - 1);
  localparam logic signed [T_W-1:0] TAP_HI     = T_W'(1) << TAP_LIM_SH;
  localparam logic signed [T_W-1:0] TAP_LO     = -TAP_HI;

  // configuration
  logic [STEP_W-1:0] fast_step, slow_step;
  logic [BLK_W-1:0]  block_length;
  logic [RUN_W-1:0]  promote_blocks;

  // per-item and scalar state
  logic signed [SAMPLE_W-1:0] x_r, d_r;
  logic [AW-1:0]              pos;
  logic [POW_W-1:0]           energy;
  logic [SQ_IN-1:0]           xsq, osq;
  logic [1:0]                 phase;
  logic                       first;
  logic [BLK_W-1:0]           block_count;
  logic [POW_W-1:0]           mic_pow, res_pow, trn_pow, echo_pow;
  logic [RUN_W-1:0]           good_run;
  logic                       promoted, slow_sel;
  action_t                    action;

  logic signed [ACC_W-1:0] acc_f, acc_b;
  logic signed [Y_W-1:0]   y, yb;
  logic signed [E_W-1:0]   err, eb;
  logic [SQ_W-1:0]         sq_d, sq_e, sq_y, sq_b;
  logic signed [P_W-1:0]   se_prod;

  // divider
  logic              div_run, div_fin, div_neg;
  logic [DC_W-1:0]   div_cnt;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_rem, div_den;
  logic [DEN_W:0]    div_trial;
  logic signed [U_W-1:0] u;
  logic [P_W-1:0]    se_mag;

  // tap walker
  logic              w_act, v1, v2;
  walk_mode_t        w_mode;
  logic [AW-1:0]     w_idx, w_j, a1, a2;
  logic signed [SAMPLE_W-1:0] ring_rd;
  logic signed [TAP_W-1:0]    fg_rd, bg_rd, tap2;
  logic signed [PR_W-1:0]     prod_f, prod_b;
  logic signed [UP_W-1:0]     prod_u;

  logic signed [SAMPLE_W-1:0] ring_mem [TAPS];
  logic signed [TAP_W-1:0]    fg_mem [TAPS];
  logic signed [TAP_W-1:0]    bg_mem [TAPS];

  // combinational helpers
  logic signed [SQ_IN-1:0]   xsq_c, osq_c;
  logic signed [POW_W+1:0]   en_sum;
  logic signed [ACC_W:0]     rnd_f, rnd_b;
  logic signed [SQ_W-1:0]    dsq_c, esq_c, ysq_c, bsq_c;
  logic [STEP_W-1:0]         step_sel;
  logic signed [P_W-1:0]     se_c;
  logic signed [PR_W-1:0]    pf_c, pb_c;
  logic signed [UP_W-1:0]    pu_c;
  logic signed [UP_W:0]      rs_u;
  logic signed [D_W-1:0]     delta;
  logic signed [T_W-1:0]     tsum;
  logic signed [TAP_W-1:0]   tap_new;
  logic [SQ_W+1:0]           trn_inc;
  logic [BLK_W-1:0]          cnt_next;
  logic [CW-1:0]             m_w, r_w, b_w, e_w, r10;
  logic                      better, do_promote, do_zero, do_restore;
  logic [RUN_W-1:0]          run_inc;

  logic                      ring_we, fg_we, bg_we;
  logic [AW-1:0]             ring_raddr, ring_waddr, bg_waddr;
  logic signed [SAMPLE_W-1:0] ring_wdata;
  logic signed [TAP_W-1:0]   fg_wdata, bg_wdata;

  function automatic logic [POW_W-1:0] add_pow(input logic [POW_W-1:0] a,
                                               input logic [SQ_W+1:0] inc);
    logic [PS_W-1:0] s;
    s = PS_W'(a) + PS_W'(inc);
    add_pow = (s > PS_W'(POW_MAX)) ? POW_MAX : s[POW_W-1:0];
  endfunction

  assign xsq_c  = x_r * x_r;
  assign osq_c  = ring_rd * ring_rd;
  assign en_sum = $signed({2'b00, energy}) + $signed((POW_W+2)'(xsq))
                - $signed((POW_W+2)'(osq));
  assign rnd_f  = (ACC_W+1)'(acc_f) + FIR_HALF;
  assign rnd_b  = (ACC_W+1)'(acc_b) + FIR_HALF;
  assign dsq_c  = d_r * d_r;
  assign esq_c  = err * err;
  assign ysq_c  = y * y;
  assign bsq_c  = eb * eb;
  assign step_sel = (first || !slow_sel) ? fast_step : slow_step;
  assign se_c   = $signed({1'b0, step_sel}) * eb;
  assign se_mag = se_prod[P_W-1] ? P_W'(-se_prod) : P_W'(se_prod);
  assign pf_c   = fg_rd * ring_rd;
  assign pb_c   = bg_rd * ring_rd;
  assign pu_c   = u * ring_rd;
  assign trn_inc = {1'b0, sq_b, 1'b0} + {2'b00, sq_b};

  // tap update: round half up to Q3.28, then clamp to plus or minus 4
  assign rs_u  = (UP_W+1)'(prod_u) + DELTA_HALF;
  assign delta = rs_u[UP_W:DELTA_SHIFT];
  assign tsum  = T_W'(tap2) + T_W'(delta);
  always_comb begin
    if (tsum > TAP_HI) tap_new = TAP_W'(TAP_HI);
    else if (tsum < TAP_LO) tap_new = TAP_W'(TAP_LO);
    else tap_new = tsum[TAP_W-1:0];
  end

  // block evaluation
  assign cnt_next = block_count + 1'b1;
  assign m_w = CW'(mic_pow);
  assign r_w = CW'(res_pow);
  assign b_w = CW'(trn_pow);
  assign e_w = CW'(echo_pow);
  assign r10 = (r_w << 3) + (r_w << 1);
  assign better = ((b_w << 1) < r_w) && ((b_w << 2) < m_w) && (m_w > CW'(ENERGY_FLOOR));
  assign run_inc = better ? ((good_run == '1) ? good_run : good_run + 1'b1) : '0;
  assign do_promote = run_inc >= promote_blocks;
  assign do_zero    = r_w > ((m_w << 1) + CW'(MARGIN));
  assign do_restore = b_w > ((r_w << 1) + CW'(MARGIN));

  assign div_trial = {div_rem, div_num[NUM_W-1]} - {1'b0, div_den};

  assign sts.walk_busy = w_act | v1 | v2;
  assign sts.div_busy  = div_run | div_fin;
  assign sts.train_en  = (phase == 2'd0) && (energy > ENERGY_FLOOR)
                         && (d_r != SAMPLE_MIN) && (d_r != SAMPLE_MAX);
  assign sts.action    = action;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_step      <= FAST_STEP_RST;
      slow_step      <= SLOW_STEP_RST;
      block_length   <= BLOCK_LEN_RST;
      promote_blocks <= PROMOTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAST_STEP: fast_step      <= cfg_data;
        REG_SLOW_STEP: slow_step      <= cfg_data;
        REG_BLOCK_LEN: block_length   <= cfg_data[BLK_W-1:0];
        REG_PROMOTE:   promote_blocks <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // scalar control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      energy      <= '0;
      phase       <= 2'd0;
      first       <= 1'b1;
      block_count <= '0;
      mic_pow     <= '0;
      res_pow     <= '0;
      trn_pow     <= '0;
      echo_pow    <= '0;
      good_run    <= '0;
      promoted    <= 1'b0;
      slow_sel    <= 1'b0;
      action      <= ACT_NONE;
    end else begin
      if (cmd.energy_upd) begin
        energy <= (en_sum < 0) ? '0 : en_sum[POW_W-1:0];
      end
      if (cmd.pow_add) begin
        mic_pow  <= add_pow(mic_pow, {2'b00, sq_d});
        res_pow  <= add_pow(res_pow, {2'b00, sq_e});
        echo_pow <= add_pow(echo_pow, {2'b00, sq_y});
        if (phase == 2'd0) trn_pow <= add_pow(trn_pow, trn_inc);
      end
      if (cmd.step_end) begin
        phase <= (phase >= 2'd2) ? 2'd0 : phase + 2'd1;
        first <= 1'b0;
        pos   <= (pos == '0) ? AW'(TAPS - 1) : pos - 1'b1;
        if (cnt_next == block_length) begin
          slow_sel    <= promoted && (r10 > e_w);
          block_count <= '0;
          mic_pow     <= '0;
          res_pow     <= '0;
          trn_pow     <= '0;
          echo_pow    <= '0;
          if (do_promote) begin
            promoted <= 1'b1;
            good_run <= '0;
            action   <= ACT_PROMOTE;
          end else if (do_zero) begin
            good_run <= '0;
            action   <= ACT_ZERO;
          end else if (do_restore) begin
            good_run <= '0;
            action   <= ACT_RESTORE;
          end else begin
            good_run <= run_inc;
            action   <= ACT_NONE;
          end
        end else begin
          block_count <= cnt_next;
          action      <= ACT_NONE;
        end
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= reference_sample;
      d_r <= mic_sample;
    end
    if (cmd.sq_energy) begin
      xsq <= xsq_c;
      osq <= osq_c;
    end
    if (cmd.fir_finish) begin
      y  <= rnd_f[ACC_W:FIR_SHIFT];
      yb <= rnd_b[ACC_W:FIR_SHIFT];
    end
    if (cmd.err_calc) begin
      err <= E_W'(d_r) - E_W'(y);
      eb  <= E_W'(d_r) - E_W'(yb);
    end
    if (cmd.sq_calc) begin
      sq_d    <= dsq_c;
      sq_e    <= esq_c;
      sq_y    <= ysq_c;
      sq_b    <= bsq_c;
      se_prod <= se_c;
    end
    if (cmd.out_load) begin
      if (err > E_W'(SAMPLE_MAX)) residual_sample <= SAMPLE_MAX;
      else if (err < E_W'(SAMPLE_MIN)) residual_sample <= SAMPLE_MIN;
      else residual_sample <= err[SAMPLE_W-1:0];
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_fin <= 1'b0;
      div_cnt <= '0;
    end else begin
      div_fin <= 1'b0;
      if (cmd.div_start) begin
        div_run <= 1'b1;
        div_cnt <= DC_W'(NUM_W);
      end else if (div_run) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DC_W'(1)) begin
          div_run <= 1'b0;
          div_fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num <= {se_mag, {STEP_SHIFT{1'b0}}};
      div_rem <= '0;
      div_den <= DEN_W'(energy) + DEN_W'(DIV_BIAS);
      div_neg <= se_prod[P_W-1];
    end else if (div_run) begin
      if (!div_trial[DEN_W]) begin
        div_rem <= div_trial[DEN_W-1:0];
        div_num <= {div_num[NUM_W-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[DEN_W-2:0], div_num[NUM_W-1]};
        div_num <= {div_num[NUM_W-2:0], 1'b0};
      end
    end else if (div_fin) begin
      u <= div_neg ? -$signed(U_W'(div_num)) : $signed(U_W'(div_num));
    end
  end

  // tap walker: issue, memory read, multiply, accumulate or write back
  always_ff @(posedge clk) begin
    if (rst) begin
      w_act  <= 1'b0;
      w_mode <= WALK_FIR;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      v1 <= w_act;
      v2 <= v1;
      if (cmd.walk_start) begin
        w_act  <= 1'b1;
        w_mode <= cmd.walk_mode;
      end else if (w_act && w_idx == AW'(TAPS - 1)) begin
        w_act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a1     <= w_idx;
    a2     <= a1;
    prod_f <= pf_c;
    prod_b <= pb_c;
    prod_u <= pu_c;
    tap2   <= bg_rd;
    if (cmd.walk_start) begin
      w_idx <= '0;
      w_j   <= pos;
      acc_f <= '0;
      acc_b <= '0;
    end else begin
      if (w_act) begin
        w_idx <= w_idx + 1'b1;
        w_j   <= (w_j == AW'(TAPS - 1)) ? '0 : w_j + 1'b1;
      end
      if (v2 && w_mode == WALK_FIR) begin
        acc_f <= acc_f + ACC_W'(prod_f);
        acc_b <= acc_b + ACC_W'(prod_b);
      end
    end
  end

  // memory ports
  assign ring_raddr = w_act ? w_j : pos;
  assign ring_we    = cmd.sq_energy || (v1 && w_mode == WALK_CLEAR);
  assign ring_waddr = cmd.sq_energy ? pos : a1;
  assign ring_wdata = cmd.sq_energy ? x_r : '0;

  assign fg_we    = v1 && (w_mode == WALK_CLEAR || w_mode == WALK_ZERO
                           || w_mode == WALK_PROMOTE);
  assign fg_wdata = (w_mode == WALK_PROMOTE) ? bg_rd : '0;

  assign bg_we    = (v2 && w_mode == WALK_UPD)
                 || (v1 && (w_mode == WALK_CLEAR || w_mode == WALK_ZERO
                            || w_mode == WALK_RESTORE));
  assign bg_waddr = (w_mode == WALK_UPD) ? a2 : a1;
  always_comb begin
    if (w_mode == WALK_UPD) bg_wdata = tap_new;
    else if (w_mode == WALK_RESTORE) bg_wdata = fg_rd;
    else bg_wdata = '0;
  end

  always_ff @(posedge clk) begin
    ring_rd <= ring_mem[ring_raddr];
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
  end

  always_ff @(posedge clk) begin
    fg_rd <= fg_mem[w_idx];
    if (fg_we) fg_mem[a1] <= fg_wdata;
  end

  always_ff @(posedge clk) begin
    bg_rd <= bg_mem[w_idx];
    if (bg_we) bg_mem[bg_waddr] <= bg_wdata;
  end

endmodule

### design/dual_filter_nlms_echo_canceller.sv
// per item: a fir walk over both tap sets, then on training samples (at most every third)
// a serial division and a tap update walk, and when a block ends with a tap copy or clear
// a sweep; all walks use the single shared tap walker
// one item at a time; the next item is taken once the result is in the output register
// synchronous active-high reset; afterwards a clearing pass zeroes the ring and both tap
// memories, and no item is accepted until it completes
module dual_filter_nlms_echo_canceller import dfnec_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] reference_sample,
  input  logic signed [SAMPLE_W-1:0] mic_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] residual_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // register writes are taken as they arrive, so the port never stalls
  assign cfg_ready = 1'b1;

  // sequencer: per item it steps through energy update, foreground and
  // background fir pass, error and power update, optional nlms division and
  // tap update pass, block evaluation and an optional tap copy or clear sweep
  dfnec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: reference ring and both tap memories, shared mac walk,
  // serial divider for the nlms step, block power statistics
  dfnec_datapath #(
    .TAPS (TAPS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .reference_sample (reference_sample),
    .mic_sample       (mic_sample),
    .residual_sample  (residual_sample)
  );

  // nothing may still be in flight while a new item can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!sts.walk_busy && !sts.div_busy))
    else $error("item accepted while datapath busy");

  // a tap walk never restarts on top of one in progress
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_start |-> !sts.walk_busy)
    else $error("walk started while busy");

  // the divider only runs for a sample that trains
  a_div_train: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> sts.train_en)
    else $error("division started without training");

endmodule

### verif/dfnec_scoreboard.sv
module dfnec_scoreboard import dfnec_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] reference_sample,
  input  logic signed [SAMPLE_W-1:0] mic_sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] residual_sample,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         errors,
  output int                         pending
);

  localparam int NT = TAPS_DEFAULT;
  localparam longint TAP_CLAMP = longint'(1) <<< TAP_LIM_SH;

  logic [STEP_W-1:0] fast_step_q, slow_step_q;
  logic [BLK_W-1:0]  blk_len_q;
  logic [RUN_W-1:0]  promote_q;

  logic signed [SAMPLE_W-1:0] ref_ring [NT];
  int                         ring_pos;
  longint unsigned            win_energy;
  int                         fg_taps [NT];
  int                         bg_taps [NT];
  int                         train_phase;
  bit                         first_sample;
  logic [BLK_W-1:0]           blk_count;
  longint unsigned            mic_pow, res_pow, train_pow, echo_pow;
  int                         good_run;
  bit                         promoted, slow_sel;

  logic signed [SAMPLE_W-1:0] residual_q [$];

  assign pending = residual_q.size();

  function automatic longint unsigned acc_power(longint unsigned acc, longint v, int mul);
    longint unsigned s;
    s = acc + longint'(v * v) * mul;
    return (s > POW_MAX) ? longint'(POW_MAX) : s;
  endfunction

  // rounded echo estimate of one tap set, newest sample first
  function automatic longint echo_estimate(bit use_bg);
    longint acc;
    int j;
    acc = 0;
    j = ring_pos;
    for (int i = 0; i < NT; i++) begin
      acc += longint'(use_bg ? bg_taps[i] : fg_taps[i]) * longint'(ref_ring[j]);
      j = (j + 1 >= NT) ? 0 : j + 1;
    end
    return (acc + (longint'(1) <<< (FIR_SHIFT - 1))) >>> FIR_SHIFT;
  endfunction

  task automatic cancel_echo(input longint x, input longint d,
                             output logic signed [SAMPLE_W-1:0] res);
    longint oldest, en, y, err, yb, eb, den, u, t;
    int pos, j;
    longint unsigned m, r, b, e;
    logic [STEP_W-1:0] stp;
    bit better;
    pos = ring_pos;
    oldest = ref_ring[pos];
    en = longint'(win_energy) + x * x - oldest * oldest;
    win_energy = (en < 0) ? 0 : en;
    ref_ring[pos] = x[SAMPLE_W-1:0];
    y = echo_estimate(1'b0);
    err = d - y;
    if (train_phase == 0) begin
      yb = echo_estimate(1'b1);
      eb = d - yb;
      stp = first_sample ? fast_step_q : (slow_sel ? slow_step_q : fast_step_q);
      if (win_energy > ENERGY_FLOOR && d != SAMPLE_MIN && d != SAMPLE_MAX) begin
        den = longint'(win_energy) + longint'(DIV_BIAS);
        u = (longint'(stp) * eb * (longint'(1) <<< STEP_SHIFT)) / den;
        j = pos;
        for (int i = 0; i < NT; i++) begin
          t = longint'(bg_taps[i]) +
              ((u * longint'(ref_ring[j]) + (longint'(1) <<< (DELTA_SHIFT - 1)))
               >>> DELTA_SHIFT);
          if (t > TAP_CLAMP) t = TAP_CLAMP;
          if (t < -TAP_CLAMP) t = -TAP_CLAMP;
          bg_taps[i] = int'(t);
          j = (j + 1 >= NT) ? 0 : j + 1;
        end
      end
      train_pow = acc_power(train_pow, eb, 3);
    end
    train_phase = (train_phase >= 2) ? 0 : train_phase + 1;
    first_sample = 1'b0;
    ring_pos = (pos == 0) ? NT - 1 : pos - 1;
    mic_pow  = acc_power(mic_pow, d, 1);
    res_pow  = acc_power(res_pow, err, 1);
    echo_pow = acc_power(echo_pow, y, 1);
    blk_count = blk_count + 1'b1;
    if (blk_count == blk_len_q) begin
      m = mic_pow; r = res_pow; b = train_pow; e = echo_pow;
      slow_sel = promoted && (10 * r > e);
      better = (2 * b < r) && (4 * b < m) && (m > ENERGY_FLOOR);
      if (better) begin
        if (good_run < 15) good_run++;
      end else begin
        good_run = 0;
      end
      if (good_run >= promote_q) begin
        fg_taps = bg_taps;
        promoted = 1'b1;
        good_run = 0;
      end else if (r > 2 * m + MARGIN) begin
        foreach (fg_taps[i]) begin
          fg_taps[i] = 0;
          bg_taps[i] = 0;
        end
        good_run = 0;
      end else if (b > 2 * r + MARGIN) begin
        bg_taps = fg_taps;
        good_run = 0;
      end
      mic_pow = 0; res_pow = 0; train_pow = 0; echo_pow = 0;
      blk_count = '0;
    end
    if (err > 32767) err = 32767;
    if (err < -32768) err = -32768;
    res = err[SAMPLE_W-1:0];
  endtask

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      fast_step_q <= FAST_STEP_RST;
      slow_step_q <= SLOW_STEP_RST;
      blk_len_q   <= BLOCK_LEN_RST;
      promote_q   <= PROMOTE_RST;
      foreach (ref_ring[i]) begin
        ref_ring[i] = '0;
        fg_taps[i] = 0;
        bg_taps[i] = 0;
      end
      ring_pos = 0; win_energy = 0; train_phase = 0; first_sample = 1'b1;
      blk_count = '0; mic_pow = 0; res_pow = 0; train_pow = 0; echo_pow = 0;
      good_run = 0; promoted = 1'b0; slow_sel = 1'b0;
      residual_q.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (residual_q.size() == 0) begin
          $error("residual_sample: no item expected, actual %0d", residual_sample);
          errors++;
        end else begin
          want = residual_q.pop_front();
          if (residual_sample !== want) begin
            $error("residual_sample: expected %0d actual %0d", want, residual_sample);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        cancel_echo(reference_sample, mic_sample, want);
        residual_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FAST_STEP: fast_step_q <= cfg_data;
          REG_SLOW_STEP: slow_step_q <= cfg_data;
          REG_BLOCK_LEN: blk_len_q   <= cfg_data[BLK_W-1:0];
          REG_PROMOTE:   promote_q   <= cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### verif/tb.sv
module tb;
  import dfnec_pkg::*;

  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd9;

  // signal shapes for the random part
  typedef enum int {SIG_ECHO, SIG_NEAR_END, SIG_NOISE, SIG_SILENT, SIG_CLIPPED} sig_kind_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] reference_sample;
  logic signed [SAMPLE_W-1:0] mic_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] residual_sample;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  int errors;
  int pending;
  int send_idle_pct;
  int stall_pct;

  // echo path of the current phase
  int echo_delay_a, echo_delay_b, echo_gain_a, echo_gain_b;
  int far_history [$];

  dual_filter_nlms_echo_canceller DUT (
    .clk, .rst, .in_valid, .in_ready, .reference_sample, .mic_sample,
    .out_valid, .out_ready, .residual_sample,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  dfnec_scoreboard scoreboard (
    .clk, .rst, .in_valid, .in_ready, .reference_sample, .mic_sample,
    .out_valid, .out_ready, .residual_sample,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver side: stall pattern set per phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input logic signed [SAMPLE_W-1:0] far,
                           input logic signed [SAMPLE_W-1:0] mic);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    reference_sample <= far;
    mic_sample       <= mic;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, let every residual drain, then cover the tail of any tap walk
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (520) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int fast, input int slow, input int blk, input int prom);
    write_reg(REG_FAST_STEP, fast[CFG_DATA_W-1:0]);
    write_reg(REG_SLOW_STEP, slow[CFG_DATA_W-1:0]);
    write_reg(REG_BLOCK_LEN, blk[CFG_DATA_W-1:0]);
    write_reg(REG_PROMOTE, prom[CFG_DATA_W-1:0]);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
    if (v > 32767) return SAMPLE_MAX;
    if (v < -32768) return SAMPLE_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    logic [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom_range(65535));
    return raw;
  endfunction

  function automatic longint past_far(input int lag);
    if (lag >= far_history.size()) return 0;
    return far_history[far_history.size() - 1 - lag];
  endfunction

  // far-end sample plus a microphone that, for echo and near-end kinds, uses the phase's echo path
  task automatic make_pair(input sig_kind_t kind,
                           output logic signed [SAMPLE_W-1:0] far,
                           output logic signed [SAMPLE_W-1:0] mic);
    longint echo, noise;
    int amp;
    amp = ($urandom_range(3) == 0) ? 32767 : $urandom_range(12000, 200);
    far = (kind == SIG_SILENT) ? SAMPLE_W'(0) : clip16($signed($urandom_range(2 * amp)) - amp);
    far_history.push_back(far);
    if (far_history.size() > 200) void'(far_history.pop_front());
    echo = (echo_gain_a * past_far(echo_delay_a) + echo_gain_b * past_far(echo_delay_b)) >>> 8;
    noise = $signed($urandom_range(64)) - 32;
    case (kind)
      SIG_ECHO:     mic = clip16(echo + noise);
      SIG_NEAR_END: mic = clip16(echo + $signed($urandom_range(40000)) - 20000);
      SIG_NOISE:    mic = any_sample();
      SIG_SILENT:   mic = clip16(noise);
      default:      mic = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    endcase
  endtask

  // one stretch of traffic: mostly clean echo so the background can converge
  task automatic run_phase(input int n_items, input int idle_pct, input int stall,
                           input int near_pct);
    logic signed [SAMPLE_W-1:0] far, mic;
    int pick;
    sig_kind_t kind;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    echo_delay_a  = $urandom_range(20);
    echo_delay_b  = $urandom_range(120, 20);
    echo_gain_a   = $signed($urandom_range(400)) - 200;
    echo_gain_b   = $signed($urandom_range(120)) - 60;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < near_pct) kind = SIG_NEAR_END;
      else if (pick < near_pct + 4) kind = SIG_NOISE;
      else if (pick < near_pct + 6) kind = SIG_SILENT;
      else if (pick < near_pct + 8) kind = SIG_CLIPPED;
      else kind = SIG_ECHO;
      make_pair(kind, far, mic);
      send_item(far, mic);
    end
    drain_block();
  endtask

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    reference_sample = '0;
    mic_sample       = '0;
    out_ready        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes at reset settings, training skipped while the ring is empty
    send_item(16'sd0, 16'sd0);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    send_item(SAMPLE_MIN, SAMPLE_MIN);
    send_item(SAMPLE_MAX, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MAX);
    send_item(16'sh5555, 16'shAAAA);
    send_item(16'shAAAA, 16'sh5555);
    send_item(16'sd1, -16'sd1);
    send_item(SAMPLE_MAX, 16'sd1000);
    send_item(SAMPLE_MIN, -16'sd1000);
    send_item(SAMPLE_MAX, 16'sd32766);
    send_item(SAMPLE_MIN, -16'sd32767);
    send_item(16'sd0, SAMPLE_MAX);
    send_item(16'sd0, SAMPLE_MIN);
    // sender holds off until every residual is back
    drain_block();

    // short blocks and quick promotion with the reset steps, no idling
    set_config(FAST_STEP_RST, SLOW_STEP_RST, 16, 2);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    run_phase(300, 0, 0, 5);

    // largest fast step, zero slow step, one-good-block promotion
    set_config(65535, 0, 5, 1);
    run_phase(200, 84, 0, 10);

    // block length 255, strictest promotion, frozen fast step
    set_config(0, 65535, 255, 15);
    run_phase(150, 0, 84, 5);

    // every sample ends a block and every block end promotes
    set_config(40000, 1000, 1, 0);
    run_phase(150, 17, 17, 10);

    // block length zero wraps to 256 samples
    set_config(30000, 3000, 0, 3);
    run_phase(150, 0, 0, 3);

    // near-end heavy traffic to drive the slow step and divergence resets
    set_config(22938, 2621, 10, 1);
    run_phase(100, 17, 17, 40);
    // lower the block length below the running count
    write_reg(REG_BLOCK_LEN, 16'd3);
    run_phase(100, 0, 0, 5);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
